// ----- rtl/core/lap_pkg.sv -----
// ----------------------------------------------------------------------------
// lap_pkg - shared types and constants for the 3x3 Laplacian edge filter
// Frame geometry, pixel and window types, and the per-word control record.
// ----------------------------------------------------------------------------
`default_nettype none

package lap_pkg;

  // Frame geometry
  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  localparam int COL_W   = $clog2(IMAGE_WIDTH);
  localparam int ROW_W   = $clog2(IMAGE_HEIGHT);
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Line buffer entry: row two above in the upper half, row above in the lower
  typedef logic [2*PIX_W-1:0] lb_word_t;

  // 3x3 window, [row][col], row 0 is the oldest line, col 2 the newest pixel
  typedef pix_t [2:0][2:0] win_t;

  // One color plane of the window, index 4 is the center
  typedef chan_t [8:0] chan_win_t;

  // Per-word control carried alongside the pixel
  typedef struct packed {
    logic   emit;
    logic   border;
    logic   last;
    coord_t col;
    coord_t row;
  } ctrl_t;

endpackage : lap_pkg

`default_nettype wire

// ----- rtl/core/laplacian_edge_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// laplacian_edge_3x3_rgb - streaming 3x3 Laplacian edge filter for RGB frames
// Line buffers, window, per-plane kernels and the word handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one RGB pixel in raster order; in_frame_start marks
//   the first pixel of a frame and restarts the column and row counters.
//   Once the incoming pixel is at column >= 1 and row >= 1, the block emits
//   the edge value of the pixel one row up and one column left, with its
//   coordinates. Row 0 and column 0 come out as zero; the last row and
//   column are never emitted, so the consumer pre-clears them.
//   out_frame_last flags the final emitted pixel of the frame.
//   Path: an accepted input word passes through the read-stage register and,
//   if it emits, the result register; either can hold it under back-pressure.
//   Throughput: one word per cycle unless the output stalls; the line memory
//   is read on accept, written as the read stage advances, with forwarding.
//   Reset clears the counters, the window and both pipeline valids; line
//   buffer contents are undefined until written and only feed zeroed rows.
//   While a result waits and out_ready is low, in_ready drops as soon as
//   the read stage holds a word that emits; it rises again with out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_edge_3x3_rgb (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lap_pkg::chan_t  in_pixel_red,
  input  wire lap_pkg::chan_t  in_pixel_green,
  input  wire lap_pkg::chan_t  in_pixel_blue,
  input  wire logic            in_frame_start,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lap_pkg::chan_t       out_edge_red,
  output lap_pkg::chan_t       out_edge_green,
  output lap_pkg::chan_t       out_edge_blue,
  output lap_pkg::coord_t      out_col,
  output lap_pkg::coord_t      out_row,
  output logic                 out_frame_last
);
  import lap_pkg::*;

  // Position counters
  col_t col_r, col_nxt, col_cur, col_m1;
  row_t row_r, row_nxt, row_cur, row_m1;
  logic col_end, row_end;
  logic in_acc;
  ctrl_t in_ctrl;

  // Read stage
  logic  s1_v_r;
  ctrl_t s1_ctrl_r;
  pix_t  s1_pix_r;
  col_t  s1_col_r;
  logic  s1_adv;
  logic  out_rdy;

  lb_word_t lb_rd;
  pix_t     lb_up, lb_lo;

  win_t      win_nxt;
  chan_win_t red_w, grn_w, blu_w;
  chan_t     red_e, grn_e, blu_e;

  // Result register
  logic  out_valid_r;
  chan_t red_r, grn_r, blu_r;
  coord_t ocol_r, orow_r;
  logic  last_r;

  assign in_acc  = in_valid && in_ready;
  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_end = (col_cur == COL_W'(IMAGE_WIDTH - 1));
  assign row_end = (row_cur == ROW_W'(IMAGE_HEIGHT - 1));
  assign col_m1  = col_cur - 1'b1;
  assign row_m1  = row_cur - 1'b1;

  // Advance the raster position
  always_comb begin
    col_nxt = col_end ? '0 : col_cur + 1'b1;
    row_nxt = row_cur;
    if (col_end) begin
      row_nxt = row_end ? '0 : row_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Tag the word with its output position
  always_comb begin
    in_ctrl.emit   = (col_cur != '0) && (row_cur != '0);
    in_ctrl.border = (col_cur == COL_W'(1)) || (row_cur == ROW_W'(1));
    in_ctrl.last   = col_end && row_end;
    in_ctrl.col    = COORD_W'(col_m1);
    in_ctrl.row    = COORD_W'(row_m1);
  end

  // Handshake: the read stage drains into the result register
  assign out_rdy  = !out_valid_r || out_ready;
  assign s1_adv   = s1_v_r && (!s1_ctrl_r.emit || out_rdy);
  assign in_ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r <= in_ctrl;
      s1_pix_r  <= {in_pixel_red, in_pixel_green, in_pixel_blue};
      s1_col_r  <= col_cur;
    end
  end

  // Line buffers: read on accept, rotate rows on advance
  assign lb_up = lb_rd[2*PIX_W-1:PIX_W];
  assign lb_lo = lb_rd[PIX_W-1:0];

  lap_linebuf u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({lb_lo, s1_pix_r}),
    .rd_data (lb_rd)
  );

  lap_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_adv),
    .col_top  (lb_up),
    .col_mid  (lb_lo),
    .col_bot  (s1_pix_r),
    .win_nxt  (win_nxt)
  );

  // Split the window into color planes
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        red_w[r*3+c] = win_nxt[r][c][3*CHAN_W-1:2*CHAN_W];
        grn_w[r*3+c] = win_nxt[r][c][2*CHAN_W-1:CHAN_W];
        blu_w[r*3+c] = win_nxt[r][c][CHAN_W-1:0];
      end
    end
  end

  lap_kernel u_kernel_red (.pix(red_w), .edge_val(red_e));
  lap_kernel u_kernel_grn (.pix(grn_w), .edge_val(grn_e));
  lap_kernel u_kernel_blu (.pix(blu_w), .edge_val(blu_e));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_ctrl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl_r.emit) begin
      red_r  <= s1_ctrl_r.border ? '0 : red_e;
      grn_r  <= s1_ctrl_r.border ? '0 : grn_e;
      blu_r  <= s1_ctrl_r.border ? '0 : blu_e;
      ocol_r <= s1_ctrl_r.col;
      orow_r <= s1_ctrl_r.row;
      last_r <= s1_ctrl_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_red   = red_r;
  assign out_edge_green = grn_r;
  assign out_edge_blue  = blu_r;
  assign out_col        = ocol_r;
  assign out_row        = orow_r;
  assign out_frame_last = last_r;

endmodule : laplacian_edge_3x3_rgb

`default_nettype wire

// ----- rtl/core/lap_linebuf.sv -----
// ----------------------------------------------------------------------------
// lap_linebuf - two-line pixel store
// One memory holds both previous rows per column; read data is registered,
// with forwarding of a same-address write in the read cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_linebuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire lap_pkg::col_t     rd_addr,
  input  wire logic              wr_en,
  input  wire lap_pkg::col_t     wr_addr,
  input  wire lap_pkg::lb_word_t wr_data,
  output lap_pkg::lb_word_t      rd_data
);
  import lap_pkg::*;

  lb_word_t mem [IMAGE_WIDTH];
  lb_word_t rd_q_r;
  lb_word_t byp_data_r;
  logic     byp_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Capture a write that lands on the address being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule : lap_linebuf

`default_nettype wire

// ----- rtl/core/lap_window.sv -----
// ----------------------------------------------------------------------------
// lap_window - 3x3 pixel window
// Shifts one column left per word and loads the new column on the right.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_window (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire lap_pkg::pix_t col_top,
  input  wire lap_pkg::pix_t col_mid,
  input  wire lap_pkg::pix_t col_bot,
  output lap_pkg::win_t      win_nxt
);
  import lap_pkg::*;

  win_t win_r;

  // Build the shifted window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_top;
    win_nxt[1][2] = col_mid;
    win_nxt[2][2] = col_bot;
  end

  // Advance on each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= win_nxt;
    end
  end

endmodule : lap_window

`default_nettype wire

// ----- rtl/core/lap_kernel.sv -----
// ----------------------------------------------------------------------------
// lap_kernel - Laplacian of one color plane
// Eight times the center minus the eight neighbors, clamped to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module lap_kernel (
  input  wire lap_pkg::chan_win_t pix,
  output lap_pkg::chan_t          edge_val
);
  import lap_pkg::*;

  localparam int SUM_W = CHAN_W + 3;

  logic [SUM_W-1:0]      nb_sum;
  logic [SUM_W-1:0]      cen8;
  logic signed [SUM_W:0] diff;

  // Sum the neighbors
  always_comb begin
    nb_sum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nb_sum = nb_sum + SUM_W'(pix[k]);
      end
    end
  end

  assign cen8 = {pix[4], 3'b000};
  assign diff = $signed({1'b0, cen8}) - $signed({1'b0, nb_sum});

  // Clamp to the pixel range
  always_comb begin
    if (diff < 0) begin
      edge_val = '0;
    end else if (diff > $signed((SUM_W+1)'(255))) begin
      edge_val = '1;
    end else begin
      edge_val = diff[CHAN_W-1:0];
    end
  end

endmodule : lap_kernel

`default_nettype wire

// ----- bench/tb_laplacian_edge_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// tb_laplacian_edge_3x3_rgb - self-checking bench for the 3x3 Laplacian filter
// Drives raster RGB words with random gaps on both handshakes and checks every
// result word against an in-bench window/line-store model. A short table of
// directed rows opens a frame, random stretches continue it, and a back to
// back burst carries a frame start in mid-frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_laplacian_edge_3x3_rgb;
  import lap_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 400;
  localparam int BURST_WORDS  = 128;
  localparam int N_DIRECTED   = 6;

  typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_SMOOTH} pixel_style_t;

  // One result word as the block should emit it
  typedef struct packed {
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    coord_t col;
    coord_t row;
    logic   last;
  } edge_word_t;

  // Directed row: repeat one pixel, optionally with fixed edge values
  typedef struct packed {
    logic [15:0] count;
    pix_t        px;
    logic        fs;
    logic        fixed;
    pix_t        fixed_edges;
  } stim_row_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  chan_t  in_pixel_red;
  chan_t  in_pixel_green;
  chan_t  in_pixel_blue;
  logic   in_frame_start;
  logic   out_valid;
  logic   out_ready;
  chan_t  out_edge_red;
  chan_t  out_edge_green;
  chan_t  out_edge_blue;
  coord_t out_col;
  coord_t out_row;
  logic   out_frame_last;

  // Model state: two line stores, the window and the raster position
  pix_t        upper_line [IMAGE_WIDTH];
  pix_t        lower_line [IMAGE_WIDTH];
  win_t        win;
  int unsigned pos_col;
  int unsigned pos_row;

  edge_word_t  edge_words_due [$];
  stim_row_t   directed_rows [N_DIRECTED];

  int   mismatch_cnt = 0;
  int   stall_cycles = 0;
  int   words_sent   = 0;
  logic tx_idle      = 1'b1;
  logic rx_idle      = 1'b1;
  logic hold_req     = 1'b0;

  laplacian_edge_3x3_rgb dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_edge_red   (out_edge_red),
    .out_edge_green (out_edge_green),
    .out_edge_blue  (out_edge_blue),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // 8 x center minus the eight neighbors, one color plane, clamped to 0..255
  function automatic chan_t plane_laplace(int sh);
    int center;
    int acc;
    int r;
    int c;
    center = int'(win[1][1][sh +: 8]);
    acc = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1)) acc += center - int'(win[r][c][sh +: 8]);
      end
    end
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return chan_t'(acc);
  endfunction

  // Advance the model by one accepted word and queue the result it causes
  function automatic void laplace_predict(pix_t px, logic fs, logic fixed, pix_t fixed_edges);
    int unsigned c;
    int unsigned r;
    int          i;
    pix_t        up;
    pix_t        lo;
    edge_word_t  w;
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= IMAGE_WIDTH) pos_col = 0;
    if (pos_row >= IMAGE_HEIGHT) pos_row = 0;
    c = pos_col;
    r = pos_row;

    // Shift the window left and load the new column
    up = upper_line[c];
    lo = lower_line[c];
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = px;
    upper_line[c] = lo;
    lower_line[c] = px;

    // Emit the center one row and one column back
    if (c >= 1 && r >= 1) begin
      w.col = coord_t'(c - 1);
      w.row = coord_t'(r - 1);
      if (c == 1 || r == 1) begin
        {w.red, w.green, w.blue} = '0;
      end else begin
        w.red   = plane_laplace(16);
        w.green = plane_laplace(8);
        w.blue  = plane_laplace(0);
      end
      if (fixed) {w.red, w.green, w.blue} = fixed_edges;
      w.last = (c == IMAGE_WIDTH - 1 && r == IMAGE_HEIGHT - 1);
      edge_words_due.push_back(w);
    end

    pos_col = c + 1;
    if (pos_col >= IMAGE_WIDTH) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= IMAGE_HEIGHT) pos_row = 0;
    end
  endfunction

  function automatic chan_t pick_chan(pixel_style_t style, chan_t base);
    int v;
    case (style)
      STYLE_UNIFORM: return chan_t'($urandom_range(0, 255));
      STYLE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: begin
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return chan_t'(v);
      end
    endcase
  endfunction

  function automatic pix_t make_pixel(pixel_style_t style, pix_t base);
    return {pick_chan(style, base[23:16]), pick_chan(style, base[15:8]),
            pick_chan(style, base[7:0])};
  endfunction

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(input pix_t px, input logic fs, input logic fixed,
                           input pix_t fixed_edges);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    {in_pixel_red, in_pixel_green, in_pixel_blue} = px;
    in_frame_start = fs;
    do @(posedge clk); while (!in_ready);
    laplace_predict(px, fs, fixed, fixed_edges);
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering until every queued result has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (edge_words_due.size() != 0) @(negedge clk);
  endtask

  // Receiver: random gap per word, plus one long hold on request
  initial begin
    int rx_wait;
    int hold_left;
    rx_wait   = 0;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (rx_wait > 0) begin
        out_ready = 1'b0;
        rx_wait--;
      end else begin
        out_ready = 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
    end
  end

  // Check each result word against the oldest queued one; track stalls
  initial begin
    edge_word_t want;
    edge_word_t got;
    forever begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (rst_n && out_valid && out_ready) begin
        got = {out_edge_red, out_edge_green, out_edge_blue, out_col, out_row, out_frame_last};
        if (edge_words_due.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result word: r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                     got.red, got.green, got.blue, got.col, got.row, got.last);
          mismatch_cnt++;
        end else begin
          want = edge_words_due.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < 10)
              $display("mismatch: want r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b, %s",
                       want.red, want.green, want.blue, want.col, want.row, want.last,
                       $sformatf("got r=%0d g=%0d b=%0d col=%0d row=%0d last=%0b",
                                 got.red, got.green, got.blue, got.col, got.row, got.last));
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin
    int           k;
    int           n;
    int           seg_len;
    int           rand_start;
    logic         held;
    pixel_style_t style;
    pix_t         base;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_red   = '0;
    in_pixel_green = '0;
    in_pixel_blue  = '0;
    in_frame_start = 1'b0;
    held           = 1'b0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    win     = '0;
    pos_col = 0;
    pos_row = 0;

    // count, pixel, frame start, fixed edges, edge value
    directed_rows = '{
      // frame start on the first word after reset, then a black row 0
      '{16'd1, 24'h000000, 1'b1, 1'b0, 24'h000000},
      '{16'(IMAGE_WIDTH - 1), 24'h000000, 1'b0, 1'b0, 24'h000000},
      // row 1: white run, then black; centers in row 0 come out zero
      '{16'd10, 24'hFFFFFF, 1'b0, 1'b1, 24'h000000},
      '{16'(IMAGE_WIDTH - 10), 24'h000000, 1'b0, 1'b1, 24'h000000},
      // row 2 black: column 0 center is zero, white centers clamp to full
      '{16'd2, 24'h000000, 1'b0, 1'b1, 24'h000000},
      '{16'd8, 24'h000000, 1'b0, 1'b1, 24'hFFFFFF}
    };

    // Hold reset, then release it at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows
    foreach (directed_rows[i]) begin
      for (k = 0; k < int'(directed_rows[i].count); k++)
        send_word(directed_rows[i].px, directed_rows[i].fs, directed_rows[i].fixed,
                  directed_rows[i].fixed_edges);
    end
    wait_drained();

    // Random stretches: continue the frame with varying pixel styles
    rand_start = words_sent;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      style   = pixel_style_t'($urandom_range(0, 2));
      base    = pix_t'($urandom);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (!held && words_sent - rand_start > 100) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      seg_len = $urandom_range(8, 64);
      for (k = 0; k < seg_len; k++)
        send_word(make_pixel(style, base), 1'b0, 1'b0, '0);
    end
    wait_drained();

    // Back to back burst, with a frame start near its end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (n = 0; n < BURST_WORDS; n++) begin
      if (n % 32 == 0) begin
        style = pixel_style_t'($urandom_range(0, 2));
        base  = pix_t'($urandom);
      end
      send_word(make_pixel(style, base), n == BURST_WORDS - 32, 1'b0, '0);
    end
    in_valid = 1'b0;

    // Drain, then keep watching for stray words
    while (edge_words_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatch_cnt == 0 && edge_words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb_laplacian_edge_3x3_rgb

`default_nettype wire
